FILE: rtl/ptt_pkg.sv
// ptt_pkg: shared types and codes for the polled task timer
// holds status codes, mode codes, action codes, register indexes, saturation limits and the config/result structs
// no dependencies
`default_nettype none

package ptt_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EARLY = 2'd1,
        ST_FIRED = 2'd2,
        ST_ARMED = 2'd3
    } t_status;

    // slot modes; the fourth code behaves as one-shot
    localparam logic [1:0] MODE_ONESHOT  = 2'd0;
    localparam logic [1:0] MODE_PERIODIC = 2'd1;
    localparam logic [1:0] MODE_LIMITED  = 2'd2;

    // actions
    localparam logic ACT_POLL = 1'b0;
    localparam logic ACT_ARM  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REL_START = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_CALLS = 3'd4;

    localparam int unsigned CFG_DATA_BITS = 32;

    // saturation limits of the signed offset
    localparam logic [31:0] LATE_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] EARLY_MAX = 32'h8000_0000;

    // configuration registers as one group
    typedef struct packed {
        logic [1:0]  mode;
        logic        relative_start;
        logic [31:0] start_time;
        logic [31:0] period;
        logic [31:0] max_calls;
    } t_cfg;

    // one result beat
    typedef struct packed {
        t_status            status;
        logic signed [31:0] time_offset;
        logic               still_armed;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/ptt_slot.sv
// ptt_slot: the timer slot state and its combinational arm/poll step
// depends on ptt_pkg (config and result structs, codes)
`default_nettype none

module ptt_slot #(
    parameter int unsigned TICK_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_action,
    input  wire logic [31:0]      i_tick,
    input  wire ptt_pkg::t_cfg    i_cfg,
    output ptt_pkg::t_result      o_result
);

    // wide enough for both the 32-bit fields and the tick width
    localparam int unsigned WB = (TICK_BITS > 32) ? TICK_BITS : 32;
    // wide enough to compare a distance against 2^31
    localparam int unsigned DW = (TICK_BITS > 33) ? TICK_BITS : 33;

    // saturation limits at distance width
    localparam logic [DW-1:0] EARLY_LIM = DW'(ptt_pkg::EARLY_MAX);
    localparam logic [DW-1:0] LATE_LIM  = DW'(ptt_pkg::LATE_MAX);

    // slot state
    logic                 r_armed;
    logic [TICK_BITS-1:0] r_due;
    logic [31:0]          r_count;
    logic [1:0]           r_mode;
    logic [TICK_BITS-1:0] r_period;
    logic [31:0]          r_limit;

    logic                 n_armed;
    logic [TICK_BITS-1:0] n_due;
    logic [31:0]          n_count;
    logic [1:0]           n_mode;
    logic [TICK_BITS-1:0] n_period;
    logic [31:0]          n_limit;

    // tick-width views of the inputs
    logic [WB-1:0]        tick_w;
    logic [WB-1:0]        start_w;
    logic [WB-1:0]        period_w;
    logic [TICK_BITS-1:0] now;
    logic [TICK_BITS-1:0] cfg_start;
    logic [TICK_BITS-1:0] cfg_period;

    // distances and saturated magnitudes
    logic                 early;
    logic [TICK_BITS-1:0] early_d;
    logic [TICK_BITS-1:0] late_d;
    logic [DW-1:0]        early_x;
    logic [DW-1:0]        late_x;
    logic [31:0]          early_mag;
    logic [31:0]          late_mag;
    logic [31:0]          count_inc;
    logic [1:0]           arm_mode;

    assign tick_w     = WB'(i_tick);
    assign start_w    = WB'(i_cfg.start_time);
    assign period_w   = WB'(i_cfg.period);
    assign now        = tick_w[TICK_BITS-1:0];
    assign cfg_start  = start_w[TICK_BITS-1:0];
    assign cfg_period = period_w[TICK_BITS-1:0];

    // due compare is plain unsigned, no wrap awareness
    assign early   = (r_due > now);
    assign early_d = r_due - now;
    assign late_d  = now - r_due;
    assign early_x = DW'(early_d);
    assign late_x  = DW'(late_d);

    assign early_mag = (early_x > EARLY_LIM) ? ptt_pkg::EARLY_MAX : early_x[31:0];
    assign late_mag  = (late_x > LATE_LIM) ? ptt_pkg::LATE_MAX : late_x[31:0];

    assign count_inc = r_count + 32'd1;

    assign arm_mode = (i_cfg.mode == ptt_pkg::MODE_PERIODIC ||
                       i_cfg.mode == ptt_pkg::MODE_LIMITED) ? i_cfg.mode
                                                           : ptt_pkg::MODE_ONESHOT;

    // next state and result of one step
    always_comb begin
        n_armed  = r_armed;
        n_due    = r_due;
        n_count  = r_count;
        n_mode   = r_mode;
        n_period = r_period;
        n_limit  = r_limit;
        o_result.status      = ptt_pkg::ST_IDLE;
        o_result.time_offset = '0;

        if (i_action == ptt_pkg::ACT_ARM) begin
            // clear the slot and schedule from the registers
            n_count  = '0;
            n_mode   = arm_mode;
            n_period = cfg_period;
            n_limit  = i_cfg.max_calls;
            n_armed  = 1'b1;
            if (arm_mode == ptt_pkg::MODE_ONESHOT) begin
                n_due = i_cfg.relative_start ? (now + cfg_start) : cfg_start;
            end else begin
                n_due = now + cfg_period;
            end
            o_result.status = ptt_pkg::ST_ARMED;
        end else if (!r_armed) begin
            o_result.status = ptt_pkg::ST_IDLE;
        end else if (early) begin
            o_result.status      = ptt_pkg::ST_EARLY;
            o_result.time_offset = $signed(32'd0 - early_mag);
        end else begin
            // fire, then reschedule or disarm
            o_result.status      = ptt_pkg::ST_FIRED;
            o_result.time_offset = $signed(late_mag);
            n_count = count_inc;
            unique case (r_mode)
                ptt_pkg::MODE_PERIODIC: begin
                    n_due = now + r_period;
                end
                ptt_pkg::MODE_LIMITED: begin
                    if (count_inc >= r_limit) begin
                        n_armed = 1'b0;
                        n_due   = '0;
                        n_count = '0;
                    end else begin
                        n_due = now + r_period;
                    end
                end
                default: begin
                    n_armed = 1'b0;
                    n_due   = '0;
                    n_count = '0;
                end
            endcase
        end
        o_result.still_armed = n_armed;
    end

    // slot registers, advanced once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed  <= 1'b0;
            r_due    <= '0;
            r_count  <= '0;
            r_mode   <= ptt_pkg::MODE_ONESHOT;
            r_period <= '0;
            r_limit  <= '0;
        end else if (i_step) begin
            r_armed  <= n_armed;
            r_due    <= n_due;
            r_count  <= n_count;
            r_mode   <= n_mode;
            r_period <= n_period;
            r_limit  <= n_limit;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/polled_task_timer_top.sv
// a beat taken into the input register passes through the slot into the result register
// one beat per cycle unless the result register stalls; the slot updates once per beat
// the input register refills while the result register is taken, so the input
// stalls only when the result register is stalled and full
// reset (synchronous, active low): slot disarmed, registers at reset values,
// both pipeline registers empty
// polled_task_timer_top: config registers, input and result registers around the slot
// depends on ptt_pkg and ptt_slot
`default_nettype none

module polled_task_timer_top #(
    parameter int unsigned TICK_BITS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [ptt_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [ptt_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_action,
    input  wire logic [31:0]                        i_current_tick,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [1:0]                              o_status,
    output logic signed [31:0]                      o_time_offset,
    output logic                                    o_still_armed
);

    ptt_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    logic             r_action;
    logic [31:0]      r_tick;
    logic             r_out_valid;
    ptt_pkg::t_result r_out;
    ptt_pkg::t_result slot_result;

    logic out_free;
    logic step;
    logic in_take;

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= ptt_pkg::MODE_ONESHOT;
            r_cfg.relative_start <= 1'b1;
            r_cfg.start_time     <= '0;
            r_cfg.period         <= '0;
            r_cfg.max_calls      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ptt_pkg::CFG_MODE:      r_cfg.mode           <= i_cfg_data[1:0];
                ptt_pkg::CFG_REL_START: r_cfg.relative_start <= i_cfg_data[0];
                ptt_pkg::CFG_START:     r_cfg.start_time     <= i_cfg_data[31:0];
                ptt_pkg::CFG_PERIOD:    r_cfg.period         <= i_cfg_data[31:0];
                ptt_pkg::CFG_MAX_CALLS: r_cfg.max_calls      <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action <= i_action;
            r_tick   <= i_current_tick;
        end
    end

    // timer slot
    ptt_slot #(
        .TICK_BITS (TICK_BITS)
    ) u_slot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_action (r_action),
        .i_tick   (r_tick),
        .i_cfg    (r_cfg),
        .o_result (slot_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= slot_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_time_offset = r_out.time_offset;
    assign o_still_armed = r_out.still_armed;

endmodule

`default_nettype wire

FILE: rtl/ptt_checker.sv
// ptt_checker: port-level assertions for the polled task timer, bound to the top
// depends on ptt_pkg (status codes) and polled_task_timer_top
`default_nettype none

module ptt_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [1:0]         o_status,
    input wire logic signed [31:0] o_time_offset,
    input wire logic               o_still_armed
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_time_offset) &&
             $stable(o_still_armed)))
        else $error("result beat changed while stalled");

    // idle and armed beats carry no offset
    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ptt_pkg::ST_IDLE || o_status == ptt_pkg::ST_ARMED))
            |-> (o_time_offset == 32'sd0))
        else $error("idle or armed beat with nonzero offset");

    // offset sign follows early versus fired
    a_offset_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_status != ptt_pkg::ST_EARLY || o_time_offset < 32'sd0) &&
             (o_status != ptt_pkg::ST_FIRED || o_time_offset >= 32'sd0)))
        else $error("offset sign disagrees with status");

    // an arm or an early poll leaves the slot armed, an idle poll leaves it disarmed
    a_armed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_status != ptt_pkg::ST_ARMED || o_still_armed) &&
             (o_status != ptt_pkg::ST_IDLE || !o_still_armed) &&
             (o_status != ptt_pkg::ST_EARLY || o_still_armed)))
        else $error("still_armed disagrees with status");

endmodule

bind polled_task_timer_top ptt_checker u_ptt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_time_offset (o_time_offset),
    .o_still_armed (o_still_armed)
);

`default_nettype wire

FILE: bench/tb_polled_task_timer_top.sv
// tb_polled_task_timer_top: self-checking bench for the polled task timer
// drives arm and poll beats, predicts each status beat in-bench, checks field by field
// depends on ptt_pkg and polled_task_timer_top
`default_nettype none

module tb_polled_task_timer_top;

    localparam int unsigned RANDOM_BEATS = 1650;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 4;

    // register index type
    typedef logic [ptt_pkg::CFG_IDX_BITS-1:0] t_idx;

    // one input beat and one predicted status beat
    typedef struct packed {
        logic        act;
        logic [31:0] tick;
    } t_tick_beat;

    typedef struct {
        ptt_pkg::t_status   status;
        logic signed [31:0] offset;
        logic               armed;
    } t_report;

    // dut signals
    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              i_cfg_we       = 1'b0;
    t_idx                              i_cfg_index    = ptt_pkg::CFG_MODE;
    logic [ptt_pkg::CFG_DATA_BITS-1:0] i_cfg_data     = '0;
    logic                              i_in_valid     = 1'b0;
    logic                              i_action       = ptt_pkg::ACT_POLL;
    logic [31:0]                       i_current_tick = '0;
    logic                              i_out_stall    = 1'b0;
    logic                              o_in_stall;
    logic                              o_out_valid;
    logic [1:0]                        o_status;
    logic signed [31:0]                o_time_offset;
    logic                              o_still_armed;

    // beats waiting for the driver and status beats the slot still owes
    t_tick_beat tick_beats_q[$];
    t_report    pending_reports[$];

    int unsigned beats_queued  = 0;
    int unsigned reports_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    // register copy
    logic [1:0]  reg_mode      = ptt_pkg::MODE_ONESHOT;
    logic        reg_rel       = 1'b1;
    logic [31:0] reg_start     = '0;
    logic [31:0] reg_period    = '0;
    logic [31:0] reg_max_calls = '0;

    // slot copy
    logic        slot_armed  = 1'b0;
    logic [31:0] slot_due    = '0;
    logic [31:0] slot_fires  = '0;
    logic [1:0]  slot_mode   = ptt_pkg::MODE_ONESHOT;
    logic [31:0] slot_period = '0;
    logic [31:0] slot_limit  = '0;

    // stimulus aiming: where the generator thinks the next due tick is
    logic [31:0] aim_due    = '0;
    logic [31:0] aim_period = '0;

    polled_task_timer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_current_tick (i_current_tick),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_time_offset  (o_time_offset),
        .o_still_armed  (o_still_armed)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // register write into the local copy
    function automatic void apply_reg(t_idx idx, logic [31:0] data);
        case (idx)
            ptt_pkg::CFG_MODE:      reg_mode      = data[1:0];
            ptt_pkg::CFG_REL_START: reg_rel       = data[0];
            ptt_pkg::CFG_START:     reg_start     = data;
            ptt_pkg::CFG_PERIOD:    reg_period    = data;
            ptt_pkg::CFG_MAX_CALLS: reg_max_calls = data;
            default: ;
        endcase
    endfunction

    function automatic void slot_clear();
        slot_armed = 1'b0;
        slot_due   = '0;
        slot_fires = '0;
    endfunction

    // advance the slot copy by one beat and return the status beat it gives
    function automatic t_report slot_step(logic act, logic [31:0] now);
        t_report     rep;
        logic [31:0] gap;
        rep.offset = '0;
        if (act == ptt_pkg::ACT_ARM) begin
            slot_clear();
            slot_mode   = (reg_mode == ptt_pkg::MODE_PERIODIC ||
                           reg_mode == ptt_pkg::MODE_LIMITED)
                          ? reg_mode : ptt_pkg::MODE_ONESHOT;
            slot_period = reg_period;
            slot_limit  = reg_max_calls;
            if (slot_mode == ptt_pkg::MODE_ONESHOT)
                slot_due = reg_rel ? now + reg_start : reg_start;
            else
                slot_due = now + slot_period;
            slot_armed = 1'b1;
            rep.status = ptt_pkg::ST_ARMED;
        end else if (!slot_armed) begin
            rep.status = ptt_pkg::ST_IDLE;
        end else if (slot_due > now) begin
            // early: negative distance, clamped at the most negative value
            rep.status = ptt_pkg::ST_EARLY;
            gap = slot_due - now;
            if (gap > ptt_pkg::EARLY_MAX)
                gap = ptt_pkg::EARLY_MAX;
            rep.offset = -gap;
        end else begin
            // fire: lateness clamped at the most positive value
            rep.status = ptt_pkg::ST_FIRED;
            gap = now - slot_due;
            rep.offset = (gap > ptt_pkg::LATE_MAX) ? ptt_pkg::LATE_MAX : gap;
            slot_fires = slot_fires + 1;
            if (slot_mode == ptt_pkg::MODE_PERIODIC) begin
                slot_due = now + slot_period;
            end else if (slot_mode == ptt_pkg::MODE_LIMITED) begin
                if (slot_fires >= slot_limit)
                    slot_clear();
                else
                    slot_due = now + slot_period;
            end else begin
                slot_clear();
            end
        end
        rep.armed = slot_armed;
        return rep;
    endfunction

    // driver: hands out queued beats, predicts each one as it is taken
    always @(posedge i_clk) begin : drive_beats
        t_tick_beat nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                pending_reports.push_back(slot_step(i_action, i_current_tick));
            if (!i_in_valid || !o_in_stall) begin
                if (tick_beats_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = tick_beats_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_action       <= nxt.act;
                    i_current_tick <= nxt.tick;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: takes status beats and checks them against the oldest prediction
    always @(posedge i_clk) begin : check_reports
        t_report want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                reports_seen = reports_seen + 1;
                if (pending_reports.size() == 0) begin
                    $error("status beat with no prediction pending");
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_time_offset !== want.offset) begin
                        $error("time_offset: expected %0d, got %0d",
                               want.offset, o_time_offset);
                        mismatches++;
                    end
                    if (o_still_armed !== want.armed) begin
                        $error("still_armed: expected %0d, got %0d",
                               want.armed, o_still_armed);
                        mismatches++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic push_beat(logic act, logic [31:0] tick);
        t_tick_beat b;
        b.act  = act;
        b.tick = tick;
        tick_beats_q.push_back(b);
        beats_queued++;
    endtask

    // wait until every beat handed out has come back, then a short drain
    task automatic settle();
        while (reports_seen != beats_queued)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_idx idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic set_regs(logic [1:0] m, logic rel, logic [31:0] start,
                            logic [31:0] per, logic [31:0] maxc);
        settle();
        write_reg(ptt_pkg::CFG_MODE, ($urandom & ~32'h3) | m);
        write_reg(ptt_pkg::CFG_REL_START, ($urandom & ~32'h1) | rel);
        write_reg(ptt_pkg::CFG_START, start);
        write_reg(ptt_pkg::CFG_PERIOD, per);
        write_reg(ptt_pkg::CFG_MAX_CALLS, maxc);
    endtask

    function automatic logic [31:0] pick_span(int unsigned hi);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    function automatic logic [31:0] pick_tick();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 15);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // arm beat plus the generator's guess of the first due tick
    task automatic arm_and_aim(logic [31:0] tick, logic [1:0] m, logic rel,
                               logic [31:0] start, logic [31:0] per);
        push_beat(ptt_pkg::ACT_ARM, tick);
        aim_period = per;
        if (m == ptt_pkg::MODE_PERIODIC || m == ptt_pkg::MODE_LIMITED)
            aim_due = tick + per;
        else
            aim_due = rel ? tick + start : start;
    endtask

    // one random setting, usually followed by an arm, then a burst of mostly aimed polls
    task automatic run_random_set();
        logic [1:0]  m;
        logic        rel;
        logic [31:0] start;
        logic [31:0] per;
        logic [31:0] t;
        t_idx        spare_idx;
        int unsigned polls;
        m     = 2'($urandom_range(0, 3));
        rel   = 1'($urandom_range(0, 1));
        start = pick_span(40);
        per   = pick_span(40);
        set_regs(m, rel, start, per, pick_span(5));
        // writes past the last register must leave everything alone
        if ($urandom_range(0, 7) == 0) begin
            spare_idx = t_idx'(ptt_pkg::CFG_MAX_CALLS + 1 + $urandom_range(0, 2));
            write_reg(spare_idx, $urandom);
        end
        // noise beats
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) push_beat(1'($urandom_range(0, 1)), $urandom);
        // most sets re-arm; the rest keep polling the slot armed earlier
        if ($urandom_range(0, 99) < 85)
            arm_and_aim(pick_tick(), m, rel, start, per);
        polls = $urandom_range(1, 12);
        repeat (polls) begin
            case ($urandom_range(0, 9))
                0, 1, 2: t = aim_due - $urandom_range(1, 8);
                3, 4:    t = aim_due;
                5, 6, 7: t = aim_due + $urandom_range(1, 8);
                8:       t = aim_due ^ 32'h8000_0000;
                default: t = $urandom;
            endcase
            if ($urandom_range(0, 15) == 0) begin
                arm_and_aim(t, m, rel, start, per);
            end else begin
                push_beat(ptt_pkg::ACT_POLL, t);
                if (t >= aim_due)
                    aim_due = t + aim_period;
            end
        end
    endtask

    // stimulus
    initial begin : stimulus
        int unsigned first_random;
        int unsigned set_index;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle slot straight out of reset
        push_beat(ptt_pkg::ACT_POLL, 32'h0000_0000);
        push_beat(ptt_pkg::ACT_POLL, 32'hFFFF_FFFF);
        // reset settings: one-shot, relative, zero delay
        push_beat(ptt_pkg::ACT_ARM, 32'd5);
        push_beat(ptt_pkg::ACT_POLL, 32'd5);
        // absolute due at the top of the range: clamped early, then fire
        set_regs(ptt_pkg::MODE_ONESHOT, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        push_beat(ptt_pkg::ACT_ARM, 32'd0);
        push_beat(ptt_pkg::ACT_POLL, 32'd0);
        push_beat(ptt_pkg::ACT_POLL, 32'hFFFF_FFFF);
        // absolute due at zero polled at the top: clamped lateness
        set_regs(ptt_pkg::MODE_ONESHOT, 1'b0, 32'd0, 32'd0, 32'd0);
        push_beat(ptt_pkg::ACT_ARM, 32'd7);
        push_beat(ptt_pkg::ACT_POLL, 32'hFFFF_FFFF);
        // relative due wraps past zero, compare is not wrap aware
        set_regs(ptt_pkg::MODE_ONESHOT, 1'b1, 32'h10, 32'd0, 32'd0);
        push_beat(ptt_pkg::ACT_ARM, 32'hFFFF_FFF8);
        push_beat(ptt_pkg::ACT_POLL, 32'hFFFF_FFFA);
        // periodic: early, on time, late
        set_regs(ptt_pkg::MODE_PERIODIC, 1'b0, 32'd0, 32'd10, 32'd0);
        push_beat(ptt_pkg::ACT_ARM, 32'd100);
        push_beat(ptt_pkg::ACT_POLL, 32'd105);
        push_beat(ptt_pkg::ACT_POLL, 32'd110);
        push_beat(ptt_pkg::ACT_POLL, 32'd125);
        // a new period after arm must not reach the armed slot
        settle();
        write_reg(ptt_pkg::CFG_PERIOD, 32'd1000);
        push_beat(ptt_pkg::ACT_POLL, 32'd135);
        push_beat(ptt_pkg::ACT_POLL, 32'd145);
        // limited to two firings
        set_regs(ptt_pkg::MODE_LIMITED, 1'b0, 32'd0, 32'd3, 32'd2);
        push_beat(ptt_pkg::ACT_ARM, 32'd0);
        push_beat(ptt_pkg::ACT_POLL, 32'd3);
        push_beat(ptt_pkg::ACT_POLL, 32'd6);
        push_beat(ptt_pkg::ACT_POLL, 32'd9);
        // limited with a zero limit fires once
        set_regs(ptt_pkg::MODE_LIMITED, 1'b0, 32'd0, 32'd3, 32'd0);
        push_beat(ptt_pkg::ACT_ARM, 32'd0);
        push_beat(ptt_pkg::ACT_POLL, 32'd3);
        // unused mode code acts as one-shot
        set_regs(2'd3, 1'b1, 32'd4, 32'd9, 32'd9);
        push_beat(ptt_pkg::ACT_ARM, 32'd0);
        push_beat(ptt_pkg::ACT_POLL, 32'd4);
        // zero period refires at the same tick; spare indexes change nothing
        set_regs(ptt_pkg::MODE_PERIODIC, 1'b0, 32'd0, 32'd0, 32'd0);
        write_reg(t_idx'(ptt_pkg::CFG_MAX_CALLS + 1), 32'hFFFF_FFFF);
        write_reg(t_idx'(ptt_pkg::CFG_MAX_CALLS + 2), 32'hFFFF_FFFF);
        write_reg(t_idx'(ptt_pkg::CFG_MAX_CALLS + 3), 32'hFFFF_FFFF);
        push_beat(ptt_pkg::ACT_ARM, 32'd7);
        push_beat(ptt_pkg::ACT_POLL, 32'd7);
        push_beat(ptt_pkg::ACT_POLL, 32'd7);

        // random sets, rotating through the idle and stall mixes
        first_random = beats_queued;
        set_index    = 0;
        while (beats_queued - first_random < RANDOM_BEATS) begin
            case (set_index % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 58; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 58; end
                default: begin send_idle_pct = 7; stall_pct = 7; end
            endcase
            run_random_set();
            set_index++;
        end

        settle();
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/ptt_pkg.sv
rtl/ptt_slot.sv
rtl/polled_task_timer_top.sv
rtl/ptt_checker.sv
bench/tb_polled_task_timer_top.sv
